### design/lbs_pkg.sv
// Types, sizes and helpers for the linear blend skinning block.
// Used by linear_blend_skinning_top; depends on nothing.
package lbs_pkg;

  localparam int MAX_BONES    = 256;
  localparam int BONE_AW      = $clog2(MAX_BONES);
  localparam int ENTRIES      = 12;
  localparam int ROW_W        = ENTRIES * 32;
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);
  localparam logic [15:0] WEIGHT_ONE = 16'h8000;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SKIN  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [7:0]         entry_bone;
    logic [3:0]         entry_slot;
    logic signed [31:0] entry_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        bone_ids;
    logic [63:0]        blend_weights;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### design/linear_blend_skinning_top.sv
// Linear blend skinning, four bones per vertex, with the bone matrix table.
// Depends on lbs_pkg (types, sizes, saturation helper).
//
//  channel | ports                           | beat
//  in      | in_valid in_ready in_data       | op 0: one matrix entry, op 1: one vertex
//  out     | out_valid out_ready out_data    | one skinned position per vertex
//
// For a vertex, one table row (one bone) is read per cycle from the
// single 384-bit wide matrix memory. Each write beat stores one entry.
// A vertex result passes the read, product, accumulate, blend and matrix registers.
// Reset clears control only; the table is undefined until written.
// A 4-deep result queue with in-flight credit lets input run while out stalls.
module linear_blend_skinning_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lbs_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lbs_pkg::out_t  out_data
);

  // sequencer
  logic        seq_busy_r, seq_busy_nxt;
  logic [1:0]  seq_k_r, seq_k_nxt;
  logic [31:0] cur_ids_r;
  logic [63:0] cur_w_r;
  logic [95:0] cur_pos_r;
  logic        seq_free, credit_ok, acc_vtx, acc_wr, pop;
  logic [2:0]  outst_r, outst_nxt;
  logic [7:0]  rd_bone;
  logic [15:0] rd_w_raw;
  logic [16:0] rd_w;

  // pipeline
  logic [lbs_pkg::ROW_W-1:0] mem [lbs_pkg::MAX_BONES];
  logic [lbs_pkg::ROW_W-1:0] rd_r;
  logic        s1_v_r, s1_first_r, s1_last_r;
  logic [16:0] s1_w_r;
  logic [95:0] s1_pos_r;
  logic signed [48:0] p_r [lbs_pkg::ENTRIES];
  logic        s2_v_r, s2_first_r, s2_last_r;
  logic [95:0] s2_pos_r;
  logic signed [50:0] acc_r [lbs_pkg::ENTRIES];
  logic        fin_v_r;
  logic [95:0] fin_pos_r;
  logic signed [31:0] blend_r [lbs_pkg::ENTRIES];
  logic        bl_v_r;
  logic [95:0] bl_pos_r;
  logic signed [63:0] prod_r [3][3];
  logic signed [31:0] trans_r [3];
  logic        pr_v_r;
  logic signed [31:0] res [3];
  logic signed [49:0] sum_c;

  // result queue
  lbs_pkg::out_t q_mem [lbs_pkg::QDEPTH];
  logic [lbs_pkg::QAW-1:0] q_wp_r, q_rp_r;
  logic [lbs_pkg::QAW:0]   q_cnt_r;

  assign seq_free  = !seq_busy_r || (seq_k_r == 2'd3);
  assign credit_ok = outst_r < 3'(lbs_pkg::QDEPTH);
  assign in_ready  = seq_free && credit_ok;
  assign acc_vtx   = in_valid && in_ready && (in_data.op == lbs_pkg::OP_SKIN);
  assign acc_wr    = in_valid && in_ready && (in_data.op == lbs_pkg::OP_WRITE);
  assign pop       = out_valid && out_ready;

  assign rd_bone  = cur_ids_r[8*seq_k_r +: 8];
  assign rd_w_raw = cur_w_r[16*seq_k_r +: 16];

  always_comb begin
    // clamp weight to 1.0; drop influence of bones beyond the table
    rd_w = (rd_w_raw > lbs_pkg::WEIGHT_ONE) ? {1'b0, lbs_pkg::WEIGHT_ONE} : {1'b0, rd_w_raw};
    if (!(9'(rd_bone) < 9'(lbs_pkg::MAX_BONES))) begin
      rd_w = '0;
    end
  end

  always_comb begin
    seq_busy_nxt = seq_busy_r;
    seq_k_nxt    = seq_k_r;
    if (acc_vtx) begin
      seq_busy_nxt = 1'b1;
      seq_k_nxt    = 2'd0;
    end else if (seq_busy_r) begin
      if (seq_k_r == 2'd3) begin
        seq_busy_nxt = 1'b0;
      end else begin
        seq_k_nxt = seq_k_r + 2'd1;
      end
    end
  end

  assign outst_nxt = outst_r + 3'(acc_vtx) - 3'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_busy_r <= 1'b0;
      seq_k_r    <= '0;
      outst_r    <= '0;
    end else begin
      seq_busy_r <= seq_busy_nxt;
      seq_k_r    <= seq_k_nxt;
      outst_r    <= outst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_vtx) begin
      cur_ids_r <= in_data.bone_ids;
      cur_w_r   <= in_data.blend_weights;
      cur_pos_r <= {in_data.pos_z, in_data.pos_y, in_data.pos_x};
    end
  end

  // table: read-first, so a write beat behind a vertex never leaks into it
  always_ff @(posedge clk) begin
    if (seq_busy_r) begin
      rd_r <= mem[rd_bone[lbs_pkg::BONE_AW-1:0]];
    end
    if (acc_wr && (in_data.entry_slot < 4'(lbs_pkg::ENTRIES))
        && (9'(in_data.entry_bone) < 9'(lbs_pkg::MAX_BONES))) begin
      mem[in_data.entry_bone[lbs_pkg::BONE_AW-1:0]][32*in_data.entry_slot +: 32]
        <= in_data.entry_value;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      fin_v_r <= 1'b0;
      bl_v_r  <= 1'b0;
      pr_v_r  <= 1'b0;
    end else begin
      s1_v_r  <= seq_busy_r;
      s2_v_r  <= s1_v_r;
      fin_v_r <= s2_v_r && s2_last_r;
      bl_v_r  <= fin_v_r;
      pr_v_r  <= bl_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_w_r     <= rd_w;
    s1_first_r <= (seq_k_r == 2'd0);
    s1_last_r  <= (seq_k_r == 2'd3);
    s1_pos_r   <= cur_pos_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_pos_r   <= s1_pos_r;
    fin_pos_r  <= s2_pos_r;
    bl_pos_r   <= fin_pos_r;
    for (int e = 0; e < lbs_pkg::ENTRIES; e++) begin
      p_r[e]     <= $signed({1'b0, s1_w_r}) * $signed(rd_r[32*e +: 32]);
      if (s2_v_r) begin
        acc_r[e] <= (s2_first_r ? 51'sd0 : acc_r[e]) + 51'(p_r[e]);
      end
      blend_r[e] <= lbs_pkg::sat32(64'(acc_r[e] >>> 15));
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[r][c] <= 64'(blend_r[4*r+c]) * 64'($signed(bl_pos_r[32*c +: 32]));
      end
      trans_r[r] <= blend_r[4*r+3];
    end
  end

  always_comb begin
    sum_c = '0;
    for (int r = 0; r < 3; r++) begin
      sum_c = 50'(prod_r[r][0] >>> 16) + 50'(prod_r[r][1] >>> 16)
            + 50'(prod_r[r][2] >>> 16) + 50'(trans_r[r]);
      res[r] = lbs_pkg::sat32(64'(sum_c));
    end
  end

  always_ff @(posedge clk) begin
    if (pr_v_r) begin
      q_mem[q_wp_r] <= '{out_x: res[0], out_y: res[1], out_z: res[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (pr_v_r) begin
        q_wp_r <= q_wp_r + 1'b1;
      end
      if (pop) begin
        q_rp_r <= q_rp_r + 1'b1;
      end
      q_cnt_r <= q_cnt_r + (lbs_pkg::QAW+1)'(pr_v_r) - (lbs_pkg::QAW+1)'(pop);
    end
  end

  assign out_valid = (q_cnt_r != '0);
  assign out_data  = q_mem[q_rp_r];

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outst_r <= 3'(lbs_pkg::QDEPTH))
    else $error("in-flight count above queue depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    pr_v_r |-> (q_cnt_r < (lbs_pkg::QAW+1)'(lbs_pkg::QDEPTH)) || pop)
    else $error("result pushed into a full queue");
  a_queue_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (lbs_pkg::QAW+1)'(q_cnt_r) <= (lbs_pkg::QAW+1)'(outst_r))
    else $error("queue holds more results than accepted vertices");
  a_hold_mid_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_busy_r && (seq_k_r != 2'd3)) |-> !in_ready)
    else $error("input taken while vertex reads are pending");
  a_vertex_start: assert property (@(posedge clk) disable iff (!rst_n)
    acc_vtx |=> seq_busy_r && (seq_k_r == 2'd0))
    else $error("vertex beat did not start the read sequence");
`endif

endmodule
